// File: hw/rtl/msgpack_value_encoder_core_defines.svh
// Assertion helpers; the asserting module provides clock and reset.
`ifndef MSGPACK_VALUE_ENCODER_CORE_DEFINES_SVH
`define MSGPACK_VALUE_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication.
`define MPENC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MPENC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mpenc_pkg.sv
package mpenc_pkg;

   typedef enum logic [3:0] {
      OP_UINT  = 4'd0,
      OP_INT   = 4'd1,
      OP_F32   = 4'd2,
      OP_BOOL  = 4'd3,
      OP_NIL   = 4'd4,
      OP_MAP   = 4'd5,
      OP_ARRAY = 4'd6,
      OP_STR   = 4'd7,
      OP_RAW   = 4'd8
   } op_type;

   localparam logic [7:0] TAG_NIL    = 8'hC0;
   localparam logic [7:0] TAG_FALSE  = 8'hC2;
   localparam logic [7:0] TAG_TRUE   = 8'hC3;
   localparam logic [7:0] TAG_F32    = 8'hCA;
   localparam logic [7:0] TAG_U8     = 8'hCC;
   localparam logic [7:0] TAG_U16    = 8'hCD;
   localparam logic [7:0] TAG_U32    = 8'hCE;
   localparam logic [7:0] TAG_U64    = 8'hCF;
   localparam logic [7:0] TAG_I8     = 8'hD0;
   localparam logic [7:0] TAG_I16    = 8'hD1;
   localparam logic [7:0] TAG_I32    = 8'hD2;
   localparam logic [7:0] TAG_I64    = 8'hD3;
   localparam logic [7:0] TAG_STR8   = 8'hD9;
   localparam logic [7:0] TAG_STR16  = 8'hDA;
   localparam logic [7:0] TAG_STR32  = 8'hDB;
   localparam logic [7:0] TAG_ARR16  = 8'hDC;
   localparam logic [7:0] TAG_ARR32  = 8'hDD;
   localparam logic [7:0] TAG_MAP16  = 8'hDE;
   localparam logic [7:0] TAG_MAP32  = 8'hDF;
   localparam logic [7:0] PFX_FIXMAP = 8'h80;
   localparam logic [7:0] PFX_FIXARR = 8'h90;
   localparam logic [7:0] PFX_FIXSTR = 8'hA0;

   // argument byte count, 0..8
   typedef logic [3:0] count_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  tag;
      logic [63:0] arg;
      count_type   nbytes;
   } enc_type;

endpackage

// File: hw/rtl/mpenc_if.sv
interface mpenc_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  operation;
   logic [63:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mpenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/mpenc_encode.sv
module mpenc_encode (
   input  logic [3:0]       operation,
   input  logic [63:0]      value,
   output mpenc_pkg::enc_type enc
);
   import mpenc_pkg::*;

   function automatic enc_type pick(logic [7:0] tag, logic [63:0] arg, count_type n);
      enc_type r;
      r.valid  = 1'b1;
      r.tag    = tag;
      r.arg    = arg;
      r.nbytes = n;
      return r;
   endfunction

   function automatic enc_type enc_uint(logic [63:0] v);
      enc_type r;
      if (v[63:7] == '0)       r = pick(v[7:0], v, 4'd0);
      else if (v[63:8] == '0)  r = pick(TAG_U8, v, 4'd1);
      else if (v[63:16] == '0) r = pick(TAG_U16, v, 4'd2);
      else if (v[63:32] == '0) r = pick(TAG_U32, v, 4'd4);
      else                     r = pick(TAG_U64, v, 4'd8);
      return r;
   endfunction

   logic [31:0] cnt;
   assign cnt = value[31:0];

   always_comb begin
      enc = '0;
      case (operation)
         OP_UINT: enc = enc_uint(value);
         OP_INT: begin
            if (!value[63])         enc = enc_uint(value);
            else if (&value[63:5])  enc = pick(value[7:0], value, 4'd0);
            else if (&value[63:7])  enc = pick(TAG_I8, value, 4'd1);
            else if (&value[63:15]) enc = pick(TAG_I16, value, 4'd2);
            else if (&value[63:31]) enc = pick(TAG_I32, value, 4'd4);
            else                    enc = pick(TAG_I64, value, 4'd8);
         end
         OP_F32:  enc = pick(TAG_F32, value, 4'd4);
         OP_BOOL: enc = pick(value[0] ? TAG_TRUE : TAG_FALSE, value, 4'd0);
         OP_NIL:  enc = pick(TAG_NIL, value, 4'd0);
         OP_MAP: begin
            if (cnt[31:4] == '0)       enc = pick(PFX_FIXMAP | {4'd0, cnt[3:0]}, value, 4'd0);
            else if (cnt[31:16] == '0) enc = pick(TAG_MAP16, value, 4'd2);
            else                       enc = pick(TAG_MAP32, value, 4'd4);
         end
         OP_ARRAY: begin
            if (cnt[31:4] == '0)       enc = pick(PFX_FIXARR | {4'd0, cnt[3:0]}, value, 4'd0);
            else if (cnt[31:16] == '0) enc = pick(TAG_ARR16, value, 4'd2);
            else                       enc = pick(TAG_ARR32, value, 4'd4);
         end
         OP_STR: begin
            if (cnt[31:5] == '0)       enc = pick(PFX_FIXSTR | {3'd0, cnt[4:0]}, value, 4'd0);
            else if (cnt[31:8] == '0)  enc = pick(TAG_STR8, value, 4'd1);
            else if (cnt[31:16] == '0) enc = pick(TAG_STR16, value, 4'd2);
            else                       enc = pick(TAG_STR32, value, 4'd4);
         end
         OP_RAW:  enc = pick(value[7:0], value, 4'd0);
         default: enc = '0;   // unused selector: no bytes
      endcase
   end

endmodule

// File: hw/rtl/mpenc_emit.sv
`include "msgpack_value_encoder_core_defines.svh"

module mpenc_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  mpenc_pkg::enc_type enc,
   output logic               free,
   mpenc_rsp_if.source        rsp
);
   import mpenc_pkg::*;

   logic        em_valid_ff, em_valid_in;
   logic        at_tag_ff, at_tag_in;
   count_type   left_ff, left_in;
   logic [7:0]  tag_ff;
   logic [63:0] arg_ff;

   logic        take, last;
   logic [2:0]  idx;

   assign last = at_tag_ff ? (left_ff == 4'd0) : (left_ff == 4'd1);
   assign idx  = 3'(left_ff - 4'd1);
   assign take = em_valid_ff && rsp.ready;
   assign free = !em_valid_ff || (rsp.ready && last);

   assign rsp.valid     = em_valid_ff;
   assign rsp.out_byte  = at_tag_ff ? tag_ff : arg_ff[{idx, 3'b000} +: 8];
   assign rsp.last_byte = last;

   always_comb begin
      em_valid_in = em_valid_ff;
      at_tag_in   = at_tag_ff;
      left_in     = left_ff;
      if (load) begin
         em_valid_in = 1'b1;
         at_tag_in   = 1'b1;
         left_in     = enc.nbytes;
      end else if (take) begin
         if (last)           em_valid_in = 1'b0;
         else if (at_tag_ff) at_tag_in   = 1'b0;
         else                left_in     = left_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         at_tag_ff   <= 1'b1;
         left_ff     <= '0;
      end else begin
         em_valid_ff <= em_valid_in;
         at_tag_ff   <= at_tag_in;
         left_ff     <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tag_ff <= enc.tag;
         arg_ff <= enc.arg;
      end
   end

   `MPENC_ASSERT_NOW(a_load_free, load, !em_valid_ff || (take && last), "load over busy item")
   `MPENC_ASSERT_NOW(a_arg_range, em_valid_ff && !at_tag_ff, left_ff != 4'd0 && left_ff <= 4'd8, "argument count out of range")
   `MPENC_ASSERT_NEXT(a_keep_going, take && !last, em_valid_ff, "item dropped before last byte")

endmodule

// File: hw/rtl/msgpack_value_encoder_core.sv
// The first byte of an item is offered once the item has passed the input register
//   and been loaded into the byte emitter.
// Throughput: one item per cycle when it encodes to one byte and the receiver takes it;
//   an item of N bytes (tag plus 0, 1, 2, 4 or 8 argument bytes) holds the byte emitter
//   until all N bytes are taken. Unused operation codes are dropped in the input register.
// Reset (synchronous, active high) empties the input register and the emitter.
module msgpack_value_encoder_core (
   input  logic        clock,
   input  logic        reset,
   mpenc_req_if.sink   req_port,
   mpenc_rsp_if.source rsp_port
);
   import mpenc_pkg::*;

   // Input register: one item waiting for the byte emitter.
   logic        in_valid_ff, in_valid_in;
   logic [3:0]  in_op_ff;
   logic [63:0] in_value_ff;

   enc_type     enc;
   logic        free, load, consume, accept;

   // Encoding is pure logic from the input register into the emitter.
   mpenc_encode u_encode (
      .operation (in_op_ff),
      .value     (in_value_ff),
      .enc       (enc)
   );

   // Item leaves the input register when the emitter can take it, or at once
   // if its operation produces no bytes.
   assign load    = in_valid_ff && enc.valid && free;
   assign consume = in_valid_ff && (!enc.valid || free);

   // Refill in the same cycle the held item moves on.
   assign req_port.ready = !in_valid_ff || consume;
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept)       in_valid_in = 1'b1;
      else if (consume) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff    <= req_port.operation;
         in_value_ff <= req_port.value;
      end
   end

   // Byte emitter: tag first, then argument bytes most significant first.
   mpenc_emit u_emit (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .enc   (enc),
      .free  (free),
      .rsp   (rsp_port)
   );

endmodule

// File: sim/mpenc_stream_checker.sv
// Watches both channels, predicts the byte stream of every accepted item and
// compares each accepted byte against the oldest prediction.
module mpenc_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [3:0]  req_operation,
   input  logic [63:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last_byte,
   output int unsigned fail_count,
   output int unsigned bytes_pending,
   output int unsigned items_seen,
   output int unsigned bytes_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import mpenc_pkg::*;

   localparam longint NEG_FIXINT_MIN = -64'sd32;
   localparam longint INT8_MIN       = -64'sd128;
   localparam longint INT16_MIN      = -64'sd32768;
   localparam longint INT32_MIN      = -64'sd2147483648;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_expect_type;

   byte_expect_type expected_bytes[$];
   int unsigned     mismatches;
   int unsigned     item_tally;
   int unsigned     byte_tally;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Shortest unsigned form: positive fixint, then 1, 2, 4 or 8 byte argument.
   function automatic void uint_form(input logic [63:0] v, output logic [7:0] tag,
                                     output int unsigned arg_len);
      tag = 8'h00;
      arg_len = 0;
      if (v <= 64'h7F) begin
         tag = v[7:0];
      end else if (v <= 64'hFF) begin
         tag = TAG_U8;
         arg_len = 1;
      end else if (v <= 64'hFFFF) begin
         tag = TAG_U16;
         arg_len = 2;
      end else if (v <= 64'hFFFF_FFFF) begin
         tag = TAG_U32;
         arg_len = 4;
      end else begin
         tag = TAG_U64;
         arg_len = 8;
      end
   endfunction

   // Returns 0 for unused operation codes (no bytes). The argument bytes are
   // the low arg_len bytes of arg, most significant first.
   function automatic bit encode_element(input logic [3:0] op, input logic [63:0] v,
                                         output logic [7:0] tag, output logic [63:0] arg,
                                         output int unsigned arg_len);
      logic [31:0] count;
      count = v[31:0];
      arg = v;
      arg_len = 0;
      tag = 8'h00;
      encode_element = 1'b1;
      case (op)
         OP_UINT: begin
            uint_form(v, tag, arg_len);
         end
         OP_INT: begin
            if (!v[63]) begin
               uint_form(v, tag, arg_len);
            end else if ($signed(v) >= NEG_FIXINT_MIN) begin
               tag = v[7:0];
            end else if ($signed(v) >= INT8_MIN) begin
               tag = TAG_I8;
               arg_len = 1;
            end else if ($signed(v) >= INT16_MIN) begin
               tag = TAG_I16;
               arg_len = 2;
            end else if ($signed(v) >= INT32_MIN) begin
               tag = TAG_I32;
               arg_len = 4;
            end else begin
               tag = TAG_I64;
               arg_len = 8;
            end
         end
         OP_F32: begin
            tag = TAG_F32;
            arg_len = 4;
         end
         OP_BOOL: begin
            tag = v[0] ? TAG_TRUE : TAG_FALSE;
         end
         OP_NIL: begin
            tag = TAG_NIL;
         end
         OP_MAP, OP_ARRAY: begin
            if (count <= 32'd15) begin
               tag = ((op == OP_MAP) ? PFX_FIXMAP : PFX_FIXARR) | {4'h0, count[3:0]};
            end else if (count <= 32'hFFFF) begin
               tag = (op == OP_MAP) ? TAG_MAP16 : TAG_ARR16;
               arg_len = 2;
            end else begin
               tag = (op == OP_MAP) ? TAG_MAP32 : TAG_ARR32;
               arg_len = 4;
            end
         end
         OP_STR: begin
            if (count <= 32'd31) begin
               tag = PFX_FIXSTR | {3'h0, count[4:0]};
            end else if (count <= 32'hFF) begin
               tag = TAG_STR8;
               arg_len = 1;
            end else if (count <= 32'hFFFF) begin
               tag = TAG_STR16;
               arg_len = 2;
            end else begin
               tag = TAG_STR32;
               arg_len = 4;
            end
         end
         OP_RAW: begin
            tag = v[7:0];
         end
         default: begin
            encode_element = 1'b0;
         end
      endcase
   endfunction

   always @(posedge clock) begin : track
      logic [7:0]      tag;
      logic [63:0]     arg;
      int unsigned     arg_len;
      byte_expect_type head;
      if (reset) begin
         expected_bytes.delete();
         mismatches = 0;
         item_tally = 0;
         byte_tally = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            byte_tally++;
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("byte %02h arrived with nothing expected",
                                         rsp_out_byte));
            end else begin
               head = expected_bytes.pop_front();
               if (rsp_out_byte !== head.data) begin
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, head.data));
               end
               if (rsp_last_byte !== head.last) begin
                  report_mismatch($sformatf("last_byte %b, expected %b on byte %02h",
                                            rsp_last_byte, head.last, head.data));
               end
            end
         end
         if (req_valid === 1'b1 && req_ready === 1'b1) begin
            item_tally++;
            if (encode_element(req_operation, req_value, tag, arg, arg_len)) begin
               expected_bytes.push_back('{data: tag, last: (arg_len == 0)});
               for (int i = arg_len; i > 0; i--) begin
                  expected_bytes.push_back('{data: arg[8*(i-1) +: 8], last: (i == 1)});
               end
            end
         end
      end
      fail_count    <= mismatches;
      bytes_pending <= expected_bytes.size();
      items_seen    <= item_tally;
      bytes_seen    <= byte_tally;
   end

endmodule

// File: sim/msgpack_value_encoder_core_tb.sv
// Testbench top: clock, reset, item stimulus, receiver stalls and the verdict.
// All stream checking lives in mpenc_stream_checker.
module msgpack_value_encoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mpenc_pkg::*;

   localparam int unsigned RESET_CYCLES    = 12;
   localparam int unsigned ITEMS_PER_PHASE = 40;
   localparam int unsigned HOLD_OFF_CYCLES = 150;  // long output stall for back-pressure
   localparam int unsigned PRESSURE_ITEMS  = 24;
   localparam int unsigned DRAIN_CYCLES    = 8;    // margin after the expected bytes have drained
   localparam int unsigned WATCHDOG_LIMIT  = 2000; // cycles with nothing accepted

   logic clock;
   logic reset;

   mpenc_req_if req_ch();
   mpenc_rsp_if rsp_ch();

   int unsigned fail_count;
   int unsigned bytes_pending;
   int unsigned items_seen;
   int unsigned bytes_seen;

   // Idle mix, in percent per cycle; changed by the stimulus between phases.
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   bit          hold_off_req;
   int unsigned quiet_cycles;

   msgpack_value_encoder_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   mpenc_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .req_value     (req_ch.value),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_out_byte  (rsp_ch.out_byte),
      .rsp_last_byte (rsp_ch.last_byte),
      .fail_count    (fail_count),
      .bytes_pending (bytes_pending),
      .items_seen    (items_seen),
      .bytes_seen    (bytes_seen)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Offer one item, with optional idle cycles in front, and return at the
   // edge where it is taken. valid is only ever assigned once per edge: either
   // lowered for an idle cycle or (re)asserted with the new item.
   task automatic send_item(input logic [3:0] op, input logic [63:0] val);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.value     <= val;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Random value with a random significant width, inverted half of the time
   // so that signed ints land in every negative size class too.
   function automatic logic [63:0] shaped_value();
      logic [63:0] bits;
      int unsigned width;
      bits = {$urandom, $urandom};
      width = $urandom_range(64, 1);
      bits = bits & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - width));
      if ($urandom_range(1, 0) == 1) begin
         bits = ~bits;
      end
      return bits;
   endfunction

   // Boundaries of size classes, ignored high bits, and unused codes.
   task automatic run_directed();
      send_item(OP_UINT, 64'h0);
      send_item(OP_UINT, 64'h7F);                     // largest positive fixint
      send_item(OP_UINT, 64'h80);                     // smallest uint8 form
      send_item(OP_UINT, 64'h1_0000);                 // smallest uint32 form
      send_item(OP_UINT, 64'hFFFF_FFFF_FFFF_FFFF);    // full uint64
      send_item(OP_INT, 64'h7F);                      // nonnegative int takes uint form
      send_item(OP_INT, -64'sd32);                    // smallest negative fixint
      send_item(OP_INT, -64'sd33);                    // largest int8
      send_item(OP_INT, -64'sd32769);                 // largest int32
      send_item(OP_INT, -64'sd2147483648);            // smallest int32
      send_item(OP_INT, 64'h8000_0000_0000_0000);     // most negative int64
      send_item(OP_F32, 64'hDEAD_BEEF_3F80_0000);     // high half ignored
      send_item(OP_BOOL, 64'hFFFF_FFFF_FFFF_FFFE);    // only bit 0 counts: false
      send_item(OP_BOOL, 64'h1);
      send_item(OP_NIL, 64'hFFFF_FFFF_FFFF_FFFF);     // nil ignores value
      send_item(OP_MAP, 64'hFFFF_FFFF_0000_000F);     // largest fixmap, high half ignored
      send_item(OP_MAP, 64'h1_0000);                  // first count in 32-bit form
      send_item(OP_ARRAY, 64'h0);
      send_item(OP_ARRAY, 64'h10);                    // first count in 16-bit form
      send_item(OP_STR, 64'd31);                      // largest fixstr
      send_item(OP_STR, 64'd32);                      // smallest str8
      send_item(OP_STR, 64'hFFFF_FFFF);               // largest str32 count
      send_item(OP_RAW, 64'hFFFF_FFFF_FFFF_FF00);
      send_item(OP_RAW, 64'hFF);
      send_item(4'd9, 64'h1234);                      // unused codes make no bytes
      send_item(4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   // Mostly single elements over all operations; about one in ten iterations
   // is a string header followed by its payload bytes.
   task automatic run_random(input int unsigned n_items);
      int unsigned sent;
      int unsigned str_len;
      logic [3:0]  op;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9, 0) == 0) begin
            str_len = $urandom_range(5, 0);
            send_item(OP_STR, {$urandom, str_len});
            repeat (str_len) send_item(OP_RAW, {$urandom, $urandom});
            sent += str_len + 1;
         end else begin
            if ($urandom_range(19, 0) == 0) begin
               op = 4'($urandom_range(15, 9));
            end else begin
               op = 4'($urandom_range(8, 0));
            end
            send_item(op, shaped_value());
            sent++;
         end
      end
   endtask

   // Receiver: random stalls, plus one long hold-off counted here on request.
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
         end
      end
   end

   // Watchdog: too long without any item or byte moving ends the run.
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_NIL;
      req_ch.value     = 64'h0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      hold_off_req     = 1'b0;
      quiet_cycles     = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Idle mixes: none, sender sparse, receiver sparse, both light.
      run_random(ITEMS_PER_PHASE);
      send_idle_pct = 83;
      run_random(ITEMS_PER_PHASE);
      send_idle_pct = 0;
      stall_pct = 83;
      run_random(ITEMS_PER_PHASE);
      send_idle_pct = 21;
      stall_pct = 21;
      run_random(ITEMS_PER_PHASE);

      // Back-pressure: output held off while nine-byte items keep coming,
      // so the emitter fills and the input must stall.
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_req = 1'b1;
      repeat (PRESSURE_ITEMS) send_item(OP_UINT, {1'b1, $urandom, 31'($urandom)});
      req_ch.valid <= 1'b0;

      while (bytes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d bytes from %0d items: every element kind at its size bounds,",
               bytes_seen, items_seen);
      $display("unused codes, string runs, four idle mixes and a %0d-cycle output hold-off",
               HOLD_OFF_CYCLES);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
